FILE: rtl/cbf_pkg.sv
// Shared types, codes and widths of the circular byte FIFO.
package cbf_pkg;

    localparam int DEPTH_DEF = 4096;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int OFF_W  = 12;
    localparam int ST_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_PEEK   = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_MORE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_NO_DATA = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  read_byte;
        logic [LEN_W-1:0]   amount;
        logic [LEN_W-1:0]   stored_len;
        logic [LEN_W-1:0]   free_len;
    } t_result;

    typedef struct packed {
        logic valid;
        logic rd_pend;
    } t_push_ctl;

endpackage

FILE: rtl/cbf_cmd_if.sv
// Request channel of the circular byte FIFO.
interface cbf_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [cbf_pkg::CMD_W-1:0]  command;
    logic [cbf_pkg::BYTE_W-1:0] data_byte;
    logic [cbf_pkg::LEN_W-1:0]  length;
    logic [cbf_pkg::OFF_W-1:0]  offset;
    logic                       last;

    modport source (output valid, command, data_byte, length, offset, last, input ready);
    modport sink (input valid, command, data_byte, length, offset, last, output ready);
endinterface

FILE: rtl/cbf_res_if.sv
// Result channel of the circular byte FIFO.
interface cbf_res_if;
    logic                       valid;
    logic                       ready;
    logic [cbf_pkg::ST_W-1:0]   status;
    logic [cbf_pkg::BYTE_W-1:0] read_byte;
    logic [cbf_pkg::LEN_W-1:0]  amount;
    logic [cbf_pkg::LEN_W-1:0]  stored_len;
    logic [cbf_pkg::LEN_W-1:0]  free_len;

    modport source (output valid, status, read_byte, amount, stored_len, free_len,
                    input ready);
    modport sink (input valid, status, read_byte, amount, stored_len, free_len,
                  output ready);
endinterface

FILE: rtl/cbf_cfg_if.sv
// Size register write channel of the circular byte FIFO.
interface cbf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cbf_pkg::LEN_W-1:0] buffer_size;

    modport source (output valid, buffer_size, input ready);
    modport sink (input valid, buffer_size, output ready);
endinterface

FILE: rtl/cbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cbf_core.sv
// Pointer, fill count and message state of the ring; drives the byte store.
module cbf_core #(
    parameter int DEPTH = cbf_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cbf_cmd_if.sink                    i_cmd,
    cbf_cfg_if.sink                    i_cfg,
    input  logic                       i_can_take,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [cbf_pkg::BYTE_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output cbf_pkg::t_result           o_push,
    output cbf_pkg::t_push_ctl         o_push_ctl
);

    localparam int PW  = $clog2(DEPTH);
    localparam int NW0 = $clog2(DEPTH + 1);
    localparam int NW  = (NW0 > cbf_pkg::LEN_W) ? NW0 : cbf_pkg::LEN_W;
    localparam int SW  = NW + 1;

    function automatic logic [PW-1:0] wrap_add(
        input logic [PW-1:0] ptr,
        input logic [NW-1:0] step,
        input logic [NW-1:0] size
    );
        logic [SW-1:0] s;
        s = SW'(ptr) + SW'(step);
        if (s >= SW'(size)) begin
            s = s - SW'(size);
        end
        if (s >= SW'(size)) begin
            s = '0;
        end
        return s[PW-1:0];
    endfunction

    logic [NW-1:0] r_size, n_size;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [NW-1:0] r_fill, n_fill;
    logic          r_msg_open, n_msg_open;
    logic          r_msg_acc, n_msg_acc;
    logic [NW-1:0] r_msg_rem, n_msg_rem;

    logic          accept;
    logic          cfg_wr;
    logic [NW-1:0] len_n;
    logic [NW-1:0] off_n;
    logic [NW-1:0] free_now;
    logic [NW-1:0] min_amt;
    logic          fits;
    logic          ins_acc;
    logic [NW-1:0] ins_rem;
    logic [NW-1:0] cfg_v;
    logic [NW-1:0] free_n;
    logic          peek_rd;
    logic [cbf_pkg::LEN_W-1:0] push_amt;
    cbf_pkg::t_status st;

    assign i_cmd.ready = i_can_take;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_cmd.valid && i_can_take;
    assign cfg_wr      = i_cfg.valid;

    assign len_n    = NW'(i_cmd.length);
    assign off_n    = NW'(i_cmd.offset);
    assign free_now = r_size - r_fill;
    assign min_amt  = (len_n < r_fill) ? len_n : r_fill;
    assign fits     = (len_n <= free_now);
    assign ins_acc  = r_msg_open ? r_msg_acc : fits;
    assign ins_rem  = r_msg_open ? r_msg_rem : (fits ? len_n : '0);

    always_comb begin
        cfg_v = NW'(i_cfg.buffer_size);
        if (cfg_v == '0) begin
            cfg_v = NW'(1);
        end
        if (cfg_v > NW'(DEPTH)) begin
            cfg_v = NW'(DEPTH);
        end
    end

    always_comb begin
        n_size     = r_size;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_fill     = r_fill;
        n_msg_open = r_msg_open;
        n_msg_acc  = r_msg_acc;
        n_msg_rem  = r_msg_rem;
        o_we       = 1'b0;
        o_re       = 1'b0;
        peek_rd    = 1'b0;
        st         = cbf_pkg::ST_DONE;
        push_amt   = '0;
        if (accept) begin
            case (i_cmd.command)
                cbf_pkg::CMD_INSERT: begin
                    n_msg_open = 1'b1;
                    n_msg_acc  = ins_acc;
                    n_msg_rem  = ins_rem;
                    if (ins_acc) begin
                        if (ins_rem != '0 && r_fill < r_size) begin
                            o_we      = 1'b1;
                            n_wr_ptr  = wrap_add(r_wr_ptr, NW'(1), r_size);
                            n_fill    = r_fill + NW'(1);
                            n_msg_rem = ins_rem - NW'(1);
                        end
                        st = i_cmd.last ? cbf_pkg::ST_DONE : cbf_pkg::ST_MORE;
                    end else begin
                        st = cbf_pkg::ST_REJECT;
                    end
                    if (i_cmd.last) begin
                        n_msg_open = 1'b0;
                        n_msg_acc  = 1'b0;
                        n_msg_rem  = '0;
                    end
                end
                cbf_pkg::CMD_PEEK: begin
                    push_amt = min_amt[cbf_pkg::LEN_W-1:0];
                    if (off_n < min_amt) begin
                        o_re    = 1'b1;
                        peek_rd = 1'b1;
                    end else begin
                        st = cbf_pkg::ST_NO_DATA;
                    end
                end
                cbf_pkg::CMD_DELETE: begin
                    push_amt = min_amt[cbf_pkg::LEN_W-1:0];
                    n_rd_ptr = wrap_add(r_rd_ptr, min_amt, r_size);
                    n_fill   = r_fill - min_amt;
                end
                default: begin
                end
            endcase
        end
        if (cfg_wr) begin
            n_size     = cfg_v;
            n_rd_ptr   = '0;
            n_wr_ptr   = '0;
            n_fill     = '0;
            n_msg_open = 1'b0;
            n_msg_acc  = 1'b0;
            n_msg_rem  = '0;
        end
    end

    assign free_n             = r_size - n_fill;
    assign o_waddr            = r_wr_ptr;
    assign o_wdata            = i_cmd.data_byte;
    assign o_raddr            = wrap_add(r_rd_ptr, off_n, r_size);
    assign o_push.status      = st;
    assign o_push.read_byte   = '0;
    assign o_push.amount      = push_amt;
    assign o_push.stored_len  = n_fill[cbf_pkg::LEN_W-1:0];
    assign o_push.free_len    = free_n[cbf_pkg::LEN_W-1:0];
    assign o_push_ctl.valid   = accept;
    assign o_push_ctl.rd_pend = peek_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= NW'(DEPTH);
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_fill     <= '0;
            r_msg_open <= 1'b0;
            r_msg_acc  <= 1'b0;
            r_msg_rem  <= '0;
        end else begin
            r_size     <= n_size;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_fill     <= n_fill;
            r_msg_open <= n_msg_open;
            r_msg_acc  <= n_msg_acc;
            r_msg_rem  <= n_msg_rem;
        end
    end

    a_fill_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_size)
        else $error("fill count exceeds ring size");

    a_ptrs_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_rd_ptr) < r_size && NW'(r_wr_ptr) < r_size)
        else $error("pointer outside ring");

    a_closed_msg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_msg_open |-> (r_msg_rem == '0 && !r_msg_acc))
        else $error("message state left over after close");

endmodule

FILE: rtl/cbf_resq.sv
// Result staging and output register; merges peek data from the byte store.
module cbf_resq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cbf_pkg::t_result           i_push,
    input  cbf_pkg::t_push_ctl         i_push_ctl,
    input  logic [cbf_pkg::BYTE_W-1:0] i_rdata,
    output logic                       o_can_take,
    cbf_res_if.source                  o_res
);

    cbf_pkg::t_result r_stg;
    logic             r_stg_valid;
    logic             r_stg_rd;
    cbf_pkg::t_result r_out;
    logic             r_out_valid;
    logic             move;

    assign move       = r_stg_valid && !r_stg_rd && (!r_out_valid || o_res.ready);
    assign o_can_take = !r_stg_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_stg_rd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push_ctl.valid) begin
                r_stg_valid <= 1'b1;
                r_stg_rd    <= i_push_ctl.rd_pend;
            end else if (move) begin
                r_stg_valid <= 1'b0;
            end else if (r_stg_rd) begin
                r_stg_rd <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_ctl.valid) begin
            r_stg <= i_push;
        end else if (r_stg_rd) begin
            r_stg.read_byte <= i_rdata;
        end
        if (move) begin
            r_out <= r_stg;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.read_byte  = r_out.read_byte;
    assign o_res.amount     = r_out.amount;
    assign o_res.stored_len = r_out.stored_len;
    assign o_res.free_len   = r_out.free_len;

    a_no_push_on_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_ctl.valid |-> !r_stg_rd)
        else $error("request pushed over a pending peek");

    a_peek_waits_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_ctl.valid && i_push_ctl.rd_pend) |=> (r_stg_rd && r_stg_valid && !move))
        else $error("peek result left stage before its byte");

    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_rd |=> !r_stg_rd || $past(i_push_ctl.valid))
        else $error("peek byte capture held longer than one cycle");

endmodule

FILE: rtl/circular_byte_fifo.sv
// Top level of the circular byte FIFO: byte ring with all-or-nothing message insert.
//
// Channels: i_cmd takes requests (insert byte, peek byte, delete bytes) under
// valid/ready; o_res returns exactly one result per request, in order; i_cfg
// writes the ring size, which also empties the ring and drops an open message.
// i_cfg is always ready; the user must write it only while no request is in flight;
// the block itself does not enforce this. A result passes the staging register and
// then the output register before it is presented on o_res; a peek result also waits
// in the staging register until the byte store read data is merged into it.
// Inserts and deletes go one per cycle while o_res takes results; the cycle after a
// peek takes no request.
// A result waiting on o_res does not stall requests until a second one is
// staged behind it; then i_cmd.ready drops until o_res.ready is seen.
// Reset: pointers, fill count and message state clear, the ring size returns
// to DEPTH; the byte store keeps its contents and needs no clearing pass.
module circular_byte_fifo #(
    parameter int DEPTH = cbf_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbf_cmd_if.sink   i_cmd,
    cbf_cfg_if.sink   i_cfg,
    cbf_res_if.source o_res
);

    localparam int PW = $clog2(DEPTH);

    logic                       we;
    logic [PW-1:0]              waddr;
    logic [cbf_pkg::BYTE_W-1:0] wdata;
    logic                       re;
    logic [PW-1:0]              raddr;
    logic [cbf_pkg::BYTE_W-1:0] rdata;
    logic                       can_take;
    cbf_pkg::t_result           push;
    cbf_pkg::t_push_ctl         push_ctl;

    cbf_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg      (i_cfg),
        .i_can_take (can_take),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .o_push     (push),
        .o_push_ctl (push_ctl)
    );

    cbf_ram #(
        .WIDTH (cbf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cbf_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ctl (push_ctl),
        .i_rdata    (rdata),
        .o_can_take (can_take),
        .o_res      (o_res)
    );

endmodule
